@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_TAKE,
    S_A_SPLIT,
    S_A_MARK,
    S_F_CHK,
    S_F_BRD,
    S_F_BCHK,
    S_F_SET
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_INVALID  = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

@@ design/bba_level_pick.sv @@
// ----------------------------------------------------------------------------
// bba_level_pick
// Finds the smallest level that fits a request and the lowest level at or
// above it that holds a free block.
// ----------------------------------------------------------------------------
module bba_level_pick import bba_pkg::*; #(
  parameter int ARENA_LEVEL = 15,
  parameter int MIN_LEVEL   = 4,
  parameter int NL          = ARENA_LEVEL - MIN_LEVEL + 1,
  parameter int LW          = $clog2(ARENA_LEVEL + 2)
) (
  input  logic [15:0]   request_size,
  input  logic [NL-1:0] level_nonzero,
  output logic [LW-1:0] need,
  output logic [LW-1:0] pick,
  output logic          found
);

  always_comb begin
    need = LW'(ARENA_LEVEL);
    for (int l = ARENA_LEVEL; l >= MIN_LEVEL; l--) begin
      if (32'(request_size) <= (32'(1) << l)) need = LW'(l);
    end
    found = 1'b0;
    pick  = '0;
    for (int k = NL - 1; k >= 0; k--) begin
      if (level_nonzero[k] && ((k + MIN_LEVEL) >= int'(need))) begin
        found = 1'b1;
        pick  = LW'(k + MIN_LEVEL);
      end
    end
  end

endmodule

@@ design/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^ARENA_LEVEL byte arena with 2^MIN_LEVEL byte granules.
//
// A transaction is taken when start is high and busy is low. operation 0
// allocates request_size bytes, operation 1 frees the block at release_offset.
// Exactly one result follows each transaction: done pulses for one cycle with
// status, block_offset and block_level. The receiver cannot stall.
// Errors found at entry are answered straight from the idle state. An allocate
// scans the free bits of the chosen level one node at a time through the
// single tree memory port, then takes the node, splits it and marks the granule.
// A free looks up the granule, checks the buddy at each level (each merge and
// the check that stops the climb below the top level) and then sets the final
// block. The tree memory port sets the pace; one transaction at a time is in
// flight.
// After reset a clearing pass sweeps the tree and granule memories; busy is
// high meanwhile.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; #(
  parameter int ARENA_LEVEL = 15,
  parameter int MIN_LEVEL   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] request_size,
  input  logic [14:0] release_offset,
  output logic        done,
  output logic [1:0]  status,
  output logic [14:0] block_offset,
  output logic [3:0]  block_level
);

  localparam int NL = ARENA_LEVEL - MIN_LEVEL + 1;
  localparam int LW = $clog2(ARENA_LEVEL + 2);
  localparam int IW = (NL > 1) ? NL - 1 : 1;
  localparam int CI = (NL > 1) ? $clog2(NL) : 1;
  localparam int AW = ARENA_LEVEL;

  state_t state, state_next;

  logic [LW-1:0] lvl, lvl_next, need, need_next, orig, orig_next;
  logic [IW-1:0] idx, idx_next;
  logic [AW-1:0] off, off_next;
  logic [NL-1:0] clr;
  logic [NL-1:0] cnt [NL];
  logic [NL-1:0] level_nonzero;

  logic          tree_mem [2**NL];
  logic [NL-1:0] tree_addr;
  logic          tree_we, tree_wd, tree_q;

  logic          gran_use_mem [2**IW];
  logic [3:0]    gran_lvl_mem [2**IW];
  logic [IW-1:0] gran_addr;
  logic          gran_we, gran_wd, gran_use_q;
  logic [3:0]    gran_lvl_q;

  logic [LW-1:0] sel_l;
  logic [IW-1:0] sel_i;
  logic          cnt_inc, cnt_dec;
  logic [CI-1:0] cnt_idx;

  logic [LW-1:0] pick_need, pick_lvl;
  logic          pick_found;
  logic [31:0]   size_ext, roff_ext, arena_bytes;
  logic [AW-1:0] alloc_off;

  logic          res_valid;
  status_t       res_status;
  logic [AW-1:0] res_off;
  logic [LW-1:0] res_lvl;

  assign size_ext    = 32'(request_size);
  assign roff_ext    = 32'(release_offset);
  assign arena_bytes = 32'(1) << ARENA_LEVEL;
  assign alloc_off   = AW'(32'(idx) << lvl);

  always_comb begin
    for (int k = 0; k < NL; k++) level_nonzero[k] = (cnt[k] != '0);
  end

  bba_level_pick #(
    .ARENA_LEVEL (ARENA_LEVEL),
    .MIN_LEVEL   (MIN_LEVEL),
    .NL          (NL),
    .LW          (LW)
  ) u_pick (
    .request_size  (request_size),
    .level_nonzero (level_nonzero),
    .need          (pick_need),
    .pick          (pick_lvl),
    .found         (pick_found)
  );

  // shared node address unit
  always_comb begin
    case (state)
      S_A_SPLIT: begin
        sel_l = lvl - LW'(1);
        sel_i = IW'((idx << 1) | IW'(1));
      end
      S_F_BRD, S_F_BCHK: begin
        sel_l = lvl;
        sel_i = idx ^ IW'(1);
      end
      default: begin
        sel_l = lvl;
        sel_i = idx;
      end
    endcase
    cnt_idx = CI'(sel_l - LW'(MIN_LEVEL));
    if (state == S_CLEAR) begin
      tree_addr = clr;
    end else begin
      tree_addr = NL'((NL'(1) << (LW'(ARENA_LEVEL) - sel_l)) - NL'(1) + NL'(sel_i));
    end
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    need_next  = need;
    orig_next  = orig;
    idx_next   = idx;
    off_next   = off;
    tree_we    = 1'b0;
    tree_wd    = 1'b0;
    gran_we    = 1'b0;
    gran_wd    = 1'b0;
    gran_addr  = IW'(off >> MIN_LEVEL);
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    res_valid  = 1'b0;
    res_status = STAT_OK;
    res_off    = '0;
    res_lvl    = '0;
    case (state)
      S_CLEAR: begin
        gran_addr = clr[IW-1:0];
        gran_we   = 1'b1;
        tree_we   = 1'b1;
        tree_wd   = (clr == '0);
        if (clr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        gran_addr = IW'(roff_ext >> MIN_LEVEL);
        if (start) begin
          if (operation == OP_ALLOC) begin
            if (size_ext == 32'd0 || size_ext > arena_bytes) begin
              res_valid  = 1'b1;
              res_status = STAT_INVALID;
            end else if (!pick_found) begin
              res_valid  = 1'b1;
              res_status = STAT_NO_SPACE;
            end else begin
              need_next  = pick_need;
              lvl_next   = pick_lvl;
              idx_next   = '0;
              state_next = S_A_RD;
            end
          end else begin
            if (roff_ext >= arena_bytes ||
                (roff_ext & ((32'(1) << MIN_LEVEL) - 32'd1)) != 32'd0) begin
              res_valid  = 1'b1;
              res_status = STAT_INVALID;
            end else begin
              off_next   = AW'(roff_ext);
              state_next = S_F_CHK;
            end
          end
        end
      end
      S_A_RD: state_next = S_A_CHK;
      S_A_CHK: begin
        if (tree_q) begin
          state_next = S_A_TAKE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_A_RD;
        end
      end
      S_A_TAKE: begin
        tree_we    = 1'b1;
        tree_wd    = 1'b0;
        cnt_dec    = 1'b1;
        state_next = (lvl == need) ? S_A_MARK : S_A_SPLIT;
      end
      S_A_SPLIT: begin
        tree_we  = 1'b1;
        tree_wd  = 1'b1;
        cnt_inc  = 1'b1;
        lvl_next = lvl - LW'(1);
        idx_next = IW'(idx << 1);
        if (lvl - LW'(1) == need) state_next = S_A_MARK;
      end
      S_A_MARK: begin
        gran_addr  = IW'(alloc_off >> MIN_LEVEL);
        gran_we    = 1'b1;
        gran_wd    = 1'b1;
        res_valid  = 1'b1;
        res_off    = alloc_off;
        res_lvl    = lvl;
        state_next = S_IDLE;
      end
      S_F_CHK: begin
        if (!gran_use_q || int'(gran_lvl_q) < MIN_LEVEL ||
            int'(gran_lvl_q) > ARENA_LEVEL) begin
          res_valid  = 1'b1;
          res_status = STAT_INVALID;
          state_next = S_IDLE;
        end else begin
          gran_we    = 1'b1;
          gran_wd    = 1'b0;
          lvl_next   = LW'(gran_lvl_q);
          orig_next  = LW'(gran_lvl_q);
          idx_next   = IW'(off >> gran_lvl_q);
          state_next = (int'(gran_lvl_q) < ARENA_LEVEL) ? S_F_BRD : S_F_SET;
        end
      end
      S_F_BRD: state_next = S_F_BCHK;
      S_F_BCHK: begin
        if (tree_q) begin
          tree_we    = 1'b1;
          tree_wd    = 1'b0;
          cnt_dec    = 1'b1;
          idx_next   = idx >> 1;
          lvl_next   = lvl + LW'(1);
          state_next = (int'(lvl) + 1 < ARENA_LEVEL) ? S_F_BRD : S_F_SET;
        end else begin
          state_next = S_F_SET;
        end
      end
      S_F_SET: begin
        tree_we    = 1'b1;
        tree_wd    = 1'b1;
        cnt_inc    = 1'b1;
        res_valid  = 1'b1;
        res_off    = off;
        res_lvl    = orig;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
      for (int k = 0; k < NL; k++) cnt[k] <= (k == NL - 1) ? NL'(1) : '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + NL'(1);
      done <= res_valid;
      if (cnt_inc) cnt[cnt_idx] <= cnt[cnt_idx] + NL'(1);
      if (cnt_dec) cnt[cnt_idx] <= cnt[cnt_idx] - NL'(1);
    end
  end

  always_ff @(posedge clk) begin
    lvl  <= lvl_next;
    need <= need_next;
    orig <= orig_next;
    idx  <= idx_next;
    off  <= off_next;
    if (res_valid) begin
      status       <= res_status;
      block_offset <= 15'(32'(res_off));
      block_level  <= 4'(res_lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_addr] <= tree_wd;
    tree_q <= tree_mem[tree_addr];
  end

  always_ff @(posedge clk) begin
    if (gran_we) gran_use_mem[gran_addr] <= gran_wd;
    if (gran_we && gran_wd) gran_lvl_mem[gran_addr] <= 4'(lvl);
    gran_use_q <= gran_use_mem[gran_addr];
    gran_lvl_q <= gran_lvl_mem[gran_addr];
  end

  assign busy = (state != S_IDLE);

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("block not busy after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("transaction neither in progress nor answered");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != STAT_RSVD)
    else $error("reserved status code");

  a_no_dual_count: assert property (@(posedge clk) disable iff (rst)
    !(cnt_inc && cnt_dec))
    else $error("free count raised and lowered at once");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for buddy_block_allocator. A generator feeds allocate and
// free transactions, mostly allocates and frees of live blocks plus noise. A
// live model of the buddy tree predicts every result, and a monitor compares
// each done strobe field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top import bba_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARENA_LVL = 15;
  localparam int MIN_LVL   = 4;
  localparam int LEVELS    = ARENA_LVL - MIN_LVL + 1;
  localparam int NODES     = (1 << LEVELS) - 1;
  localparam int GRANS     = 1 << (ARENA_LVL - MIN_LVL);

  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [14:0] offset;
  } request_t;

  typedef struct {
    status_t     st;
    logic [14:0] offset;
    logic [3:0]  level;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        operation = OP_ALLOC;
  logic [15:0] request_size = '0;
  logic [14:0] release_offset = '0;
  logic        busy, done;
  logic [1:0]  status;
  logic [14:0] block_offset;
  logic [3:0]  block_level;

  request_t    request_q[$];
  grant_t      grant_q[$];
  int          live_blocks[$];
  int          errors = 0;
  int          sent = 0;

  bit          node_free[NODES];
  int          level_count[LEVELS];
  bit          gran_used[GRANS];
  int          gran_level[GRANS];

  buddy_block_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .request_size(request_size),
    .release_offset(release_offset), .done(done), .status(status),
    .block_offset(block_offset), .block_level(block_level)
  );

  always #2 clk = ~clk;

  function automatic int node_at(int lvl, int idx);
    return ((1 << (ARENA_LVL - lvl)) - 1) + idx;
  endfunction

  function automatic void mark_node(int lvl, int idx, bit v);
    int n;
    n = node_at(lvl, idx);
    if (n >= NODES) return;
    if (v && !node_free[n]) begin
      node_free[n] = 1'b1;
      level_count[lvl - MIN_LVL]++;
    end else if (!v && node_free[n]) begin
      node_free[n] = 1'b0;
      level_count[lvl - MIN_LVL]--;
    end
  endfunction

  function automatic bit node_is_free(int lvl, int idx);
    int n;
    n = node_at(lvl, idx);
    return n < NODES && node_free[n];
  endfunction

  function automatic grant_t allocate_block(int size);
    grant_t g;
    int need, lvl, idx, cnt;
    g = '{STAT_INVALID, '0, '0};
    if (size == 0 || size > (1 << ARENA_LVL)) return g;
    g.st = STAT_NO_SPACE;
    need = MIN_LVL;
    while ((1 << need) < size) need++;
    lvl = need;
    while (lvl <= ARENA_LVL && level_count[lvl - MIN_LVL] == 0) lvl++;
    if (lvl > ARENA_LVL) return g;
    cnt = 1 << (ARENA_LVL - lvl);
    for (idx = 0; idx < cnt; idx++)
      if (node_is_free(lvl, idx)) break;
    if (idx >= cnt) return g;
    mark_node(lvl, idx, 1'b0);
    while (lvl > need) begin
      lvl--;
      idx = idx << 1;
      mark_node(lvl, idx + 1, 1'b1);
    end
    gran_used[(idx << lvl) >> MIN_LVL] = 1'b1;
    gran_level[(idx << lvl) >> MIN_LVL] = lvl;
    live_blocks.insert(live_blocks.size(), idx << lvl);
    g = '{STAT_OK, 15'(idx << lvl), 4'(lvl)};
    return g;
  endfunction

  function automatic grant_t release_block(int off);
    grant_t g;
    int gi, lvl, idx;
    g = '{STAT_INVALID, '0, '0};
    if (off >= (1 << ARENA_LVL) || (off & ((1 << MIN_LVL) - 1)) != 0) return g;
    gi = off >> MIN_LVL;
    if (!gran_used[gi]) return g;
    lvl = gran_level[gi];
    g = '{STAT_OK, 15'(off), 4'(lvl)};
    gran_used[gi] = 1'b0;
    idx = off >> lvl;
    while (lvl < ARENA_LVL && node_is_free(lvl, idx ^ 1)) begin
      mark_node(lvl, idx ^ 1, 1'b0);
      idx = idx >> 1;
      lvl++;
    end
    mark_node(lvl, idx, 1'b1);
    foreach (live_blocks[i])
      if (live_blocks[i] == off) begin
        live_blocks.delete(i);
        break;
      end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    request_t r;
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        if (operation == OP_FREE)
          grant_q.insert(grant_q.size(), release_block(release_offset));
        else grant_q.insert(grant_q.size(), allocate_block(request_size));
      end
      idle_pct = (sent < 180) ? 34 : (sent < 360) ? 46 : 0;
      if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        r = request_q.pop_front();
        sent++;
        start <= 1'b1;
        operation <= r.op;
        request_size <= r.size;
        release_offset <= r.offset;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t g;
    if (!rst && done) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected transaction, status", status, 0);
      end else begin
        g = grant_q.pop_front();
        if (status != g.st) report_mismatch("status", status, g.st);
        if (block_offset != g.offset) report_mismatch("block_offset", block_offset, g.offset);
        if (block_level != g.level) report_mismatch("block_level", block_level, g.level);
      end
    end
  end

  task automatic send(logic op, int size, int off);
    request_t r;
    while (request_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk);
    r = '{op, 16'(size), 15'(off)};
    request_q.insert(request_q.size(), r);
    @(negedge clk);
  endtask

  initial begin
    int pick, n, k;
    foreach (node_free[i]) node_free[i] = 1'b0;
    foreach (level_count[i]) level_count[i] = 0;
    foreach (gran_used[i]) gran_used[i] = 1'b0;
    foreach (gran_level[i]) gran_level[i] = 0;
    node_free[0] = 1'b1;
    level_count[LEVELS - 1] = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(OP_ALLOC, 16, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 17, 0);
    send(OP_ALLOC, 32768, 0);
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 32769, 0);
    send(OP_ALLOC, 65535, 0);
    send(OP_FREE, 0, 8);
    send(OP_FREE, 0, 32767);
    send(OP_FREE, 0, 32752);
    send(OP_FREE, 0, 16);
    send(OP_FREE, 0, 16);
    send(OP_FREE, 0, 48);
    send(OP_FREE, 0, 0);
    send(OP_FREE, 0, 32);
    send(OP_ALLOC, 32768, 0);
    send(OP_ALLOC, 16, 0);
    send(OP_FREE, 0, 0);
    send(OP_ALLOC, 16384, 0);
    send(OP_ALLOC, 16385, 0);
    send(OP_ALLOC, 16384, 0);
    send(OP_FREE, 0, 16384);
    send(OP_FREE, 0, 0);

    for (n = 0; n < 500; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 && live_blocks.size() < 40) begin
        k = $urandom_range(0, 99);
        if (k < 70) send(OP_ALLOC, $urandom_range(1, 128), 0);
        else if (k < 90) send(OP_ALLOC, $urandom_range(1, 32768), 0);
        else if (k < 95) send(OP_ALLOC, 0, $urandom_range(0, 32767));
        else send(OP_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 32767));
      end else if (pick < 88 && live_blocks.size() != 0) begin
        send(OP_FREE, $urandom_range(0, 65535),
             live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else begin
        k = $urandom_range(0, 2);
        if (k == 0) send(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 32767));
        else if (k == 1) send(OP_FREE, 0, $urandom_range(0, 2047) << 4);
        else send(OP_FREE, 0, ($urandom_range(0, 2047) << 4) | $urandom_range(1, 15));
      end
    end

    while (request_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
